/* design/linear_interp_upsampler_defines.svh */
// Assertion macros of the upsampler RTL, used by the back end.
`ifndef LINEAR_INTERP_UPSAMPLER_DEFINES_SVH
`define LINEAR_INTERP_UPSAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LIU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LIU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/liu_pkg.sv */
// Types and constants of the linear interpolation upsampler.
`default_nettype none

package liu_pkg;

    localparam int unsigned FACTOR     = 10;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned PHASE_W    = 4;
    localparam int unsigned REM_W      = $clog2(FACTOR);
    localparam int unsigned DIFF_W     = DATA_W + 1;
    localparam int unsigned DIV_STEP   = 8;
    localparam int unsigned DIV_STAGES = (DIFF_W + 1 + REM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int unsigned DIV_W      = DIV_STAGES * DIV_STEP;
    localparam int unsigned BIAS_W     = DIV_W - DIFF_W;
    localparam int unsigned QUEUE_AW   = 1;
    localparam int unsigned QUEUE_DEPTH = 2 ** QUEUE_AW;

    localparam logic [REM_W:0]       FACTOR_R   = (REM_W + 1)'(FACTOR);
    localparam logic [PHASE_W-1:0]   PHASE_LAST = PHASE_W'(FACTOR - 1);

    typedef struct packed {
        logic signed [DATA_W-1:0] x_in;
        logic signed [DATA_W-1:0] y_in;
        logic                     start_req;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_out;
        logic signed [DATA_W-1:0] y_out;
        logic [PHASE_W-1:0]       phase;
        logic                     last;
    } t_out_item;

    // One segment for the back end: start point, per-step quotient and remainder.
    typedef struct packed {
        logic [DATA_W-1:0] x0;
        logic [DATA_W-1:0] y0;
        logic [DATA_W-1:0] qdx;
        logic [DATA_W-1:0] qdy;
        logic [REM_W-1:0]  rdx;
        logic [REM_W-1:0]  rdy;
    } t_seg_cmd;

endpackage

`default_nettype wire

/* design/liu_front.sv */
// Front end: accepts points, tracks the previous point, splits each step by FACTOR.
`default_nettype none

module liu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  liu_pkg::t_in_item  i_in,
    output logic               o_push,
    output liu_pkg::t_seg_cmd  o_push_data,
    input  logic               i_full
);
    import liu_pkg::*;

    typedef struct packed {
        logic [DIV_W-1:0] dv;
        logic [REM_W-1:0] rm;
    } t_div_lane;

    // Biased dividend: d + FACTOR * 2^DIFF_W is never negative and keeps the remainder.
    function automatic t_div_lane div_init(logic [DIFF_W-1:0] d);
        t_div_lane v;
        v.dv = {BIAS_W'(FACTOR) - BIAS_W'(d[DIFF_W-1]), d};
        v.rm = '0;
        return v;
    endfunction

    // Restoring long division by FACTOR, DIV_STEP quotient bits.
    function automatic t_div_lane div_steps(t_div_lane a);
        t_div_lane        v;
        logic [REM_W:0]   t;
        logic             ge;
        v = a;
        for (int b = 0; b < DIV_STEP; b++) begin
            t    = {v.rm, v.dv[DIV_W-1]};
            ge   = (t >= FACTOR_R);
            v.rm = ge ? REM_W'(t - FACTOR_R) : t[REM_W-1:0];
            v.dv = {v.dv[DIV_W-2:0], ge};
        end
        return v;
    endfunction

    logic signed [DATA_W-1:0] r_prev_x;
    logic signed [DATA_W-1:0] r_prev_y;
    logic                     r_have_prev;
    logic [DIV_STAGES:0]      r_vld;
    t_div_lane                r_lx [DIV_STAGES+1];
    t_div_lane                r_ly [DIV_STAGES+1];
    logic [DATA_W-1:0]        r_x0 [DIV_STAGES+1];
    logic [DATA_W-1:0]        r_y0 [DIV_STAGES+1];

    logic              w_adv;
    logic              w_acc;
    logic              w_seg;
    logic [DIFF_W-1:0] w_dx;
    logic [DIFF_W-1:0] w_dy;

    assign w_adv = !(r_vld[DIV_STAGES] && i_full);
    assign w_acc = i_in_valid && w_adv;
    assign w_seg = !i_in.start_req && r_have_prev;
    assign w_dx  = DIFF_W'(i_in.x_in) - DIFF_W'(r_prev_x);
    assign w_dy  = DIFF_W'(i_in.y_in) - DIFF_W'(r_prev_y);

    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_vld       <= '0;
        end else begin
            if (w_acc) begin
                r_prev_x    <= i_in.x_in;
                r_prev_y    <= i_in.y_in;
                r_have_prev <= 1'b1;
            end
            if (w_adv) begin
                r_vld <= {r_vld[DIV_STAGES-1:0], w_acc && w_seg};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lx[0] <= div_init(w_dx);
            r_ly[0] <= div_init(w_dy);
            r_x0[0] <= r_prev_x;
            r_y0[0] <= r_prev_y;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_lx[k] <= div_steps(r_lx[k-1]);
                r_ly[k] <= div_steps(r_ly[k-1]);
                r_x0[k] <= r_x0[k-1];
                r_y0[k] <= r_y0[k-1];
            end
        end
    end

    // Quotient minus the bias is the same modulo 2^DATA_W, so keep the low bits.
    assign o_push           = r_vld[DIV_STAGES] && !i_full;
    assign o_push_data.x0   = r_x0[DIV_STAGES];
    assign o_push_data.y0   = r_y0[DIV_STAGES];
    assign o_push_data.qdx  = r_lx[DIV_STAGES].dv[DATA_W-1:0];
    assign o_push_data.qdy  = r_ly[DIV_STAGES].dv[DATA_W-1:0];
    assign o_push_data.rdx  = r_lx[DIV_STAGES].rm;
    assign o_push_data.rdy  = r_ly[DIV_STAGES].rm;

endmodule

`default_nettype wire

/* design/liu_queue.sv */
// Short segment queue between the front end and the back end.
`default_nettype none

module liu_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  liu_pkg::t_seg_cmd  i_push_data,
    output logic               o_full,
    output logic               o_valid,
    output liu_pkg::t_seg_cmd  o_data,
    input  logic               i_pop
);
    import liu_pkg::*;

    t_seg_cmd              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wp;
    logic [QUEUE_AW-1:0]   r_rp;
    logic [QUEUE_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QUEUE_AW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QUEUE_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

/* design/liu_back.sv */
// Back end: walks a segment by running quotient and remainder; one result per ready cycle.
`default_nettype none
`include "linear_interp_upsampler_defines.svh"

module liu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  liu_pkg::t_seg_cmd  i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output liu_pkg::t_out_item o_out
);
    import liu_pkg::*;

    logic               r_busy;
    logic [PHASE_W-1:0] r_phase;
    logic [DATA_W-1:0]  r_x;
    logic [DATA_W-1:0]  r_y;
    logic [REM_W-1:0]   r_rx;
    logic [REM_W-1:0]   r_ry;
    logic [DATA_W-1:0]  r_qdx;
    logic [DATA_W-1:0]  r_qdy;
    logic [REM_W-1:0]   r_rdx;
    logic [REM_W-1:0]   r_rdy;

    logic               w_xfer;
    logic               w_done;
    logic               w_load;
    logic [REM_W:0]     w_sx;
    logic [REM_W:0]     w_sy;
    logic               w_cx;
    logic               w_cy;
    logic [REM_W-1:0]   n_rx;
    logic [REM_W-1:0]   n_ry;
    logic [DATA_W-1:0]  n_x;
    logic [DATA_W-1:0]  n_y;
    logic               w_step;
    logic               w_fresh;
    logic [PHASE_W-1:0] w_phase_nx;

    assign w_xfer = r_busy && i_out_ready;
    assign w_done = w_xfer && (r_phase == PHASE_LAST);
    assign w_load = i_cmd_valid && (!r_busy || w_done);

    // Carry a unit into the quotient when the remainders add up to FACTOR or more.
    assign w_sx = {1'b0, r_rx} + {1'b0, r_rdx};
    assign w_sy = {1'b0, r_ry} + {1'b0, r_rdy};
    assign w_cx = (w_sx >= FACTOR_R);
    assign w_cy = (w_sy >= FACTOR_R);
    assign n_rx = w_cx ? REM_W'(w_sx - FACTOR_R) : w_sx[REM_W-1:0];
    assign n_ry = w_cy ? REM_W'(w_sy - FACTOR_R) : w_sy[REM_W-1:0];
    assign n_x  = r_x + r_qdx + DATA_W'(w_cx);
    assign n_y  = r_y + r_qdy + DATA_W'(w_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
        end else begin
            if (w_load) begin
                r_busy  <= 1'b1;
                r_phase <= '0;
            end else begin
                if (w_done) begin
                    r_busy <= 1'b0;
                end
                if (w_xfer) begin
                    r_phase <= r_phase + PHASE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x   <= i_cmd.x0;
            r_y   <= i_cmd.y0;
            r_rx  <= '0;
            r_ry  <= '0;
            r_qdx <= i_cmd.qdx;
            r_qdy <= i_cmd.qdy;
            r_rdx <= i_cmd.rdx;
            r_rdy <= i_cmd.rdy;
        end else if (w_xfer) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_rx <= n_rx;
            r_ry <= n_ry;
        end
    end

    assign o_cmd_pop   = w_load;
    assign o_out_valid = r_busy;
    assign o_out.x_out = r_x;
    assign o_out.y_out = r_y;
    assign o_out.phase = r_phase;
    assign o_out.last  = (r_phase == PHASE_LAST);

    // Terms for the checks below.
    assign w_step     = w_xfer && !w_done;
    assign w_phase_nx = r_phase + PHASE_W'(1);
    assign w_fresh    = (r_phase == '0) && (r_rx == '0) && (r_ry == '0);

    `LIU_ASSERT_IMP(a_phase_range, r_busy, r_phase <= PHASE_LAST, "phase past last step")
    `LIU_ASSERT_NXT(a_phase_step, w_step, r_busy && r_phase == $past(w_phase_nx), "phase stuck")
    `LIU_ASSERT_NXT(a_idle_after_last, w_done && !i_cmd_valid, !r_busy, "busy after segment end")
    `LIU_ASSERT_NXT(a_load_restart, o_cmd_pop, r_busy && w_fresh, "segment load did not restart")

endmodule

`default_nettype wire

/* design/linear_interp_upsampler.sv */
// Top level of the linear interpolation upsampler.
// Takes signed Q16.16 (x, y) points; each point after the first (and without
// start_req) yields FACTOR results walking the segment from the previous point,
// result j being x0 + floor(j*dx/FACTOR), y0 + floor(j*dy/FACTOR), phase j, and
// last set on j = FACTOR-1. A start point, or the first point after reset, is
// stored and yields nothing. The output stage delivers one result per cycle while
// the consumer is ready. The front end splits each step by FACTOR in a pipelined
// long divider of DIV_STAGES stages (5 here). A two-entry queue parts the divider
// from the result stage, so points keep flowing in while results wait for the
// consumer, until the queue and the divider are full.
`default_nettype none

module linear_interp_upsampler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  liu_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output liu_pkg::t_out_item o_out
);
    import liu_pkg::*;

    // Segment commands from the divider into the queue and out to the walker.
    logic     w_push;
    t_seg_cmd w_push_data;
    logic     w_full;
    logic     w_cmd_valid;
    t_seg_cmd w_cmd;
    logic     w_cmd_pop;

    // Classify each point, hold the previous one, divide the step by FACTOR.
    liu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full)
    );

    // Hold finished segments while the back end is still busy.
    liu_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .o_valid     (w_cmd_valid),
        .o_data      (w_cmd),
        .i_pop       (w_cmd_pop)
    );

    // Advance through the segment on each output transfer.
    liu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench of the upsampler: a directed point table, then random point streams.
module tb_top;
    import liu_pkg::*;

    localparam longint STEPS       = FACTOR;
    localparam int     RAND_POINTS = 100;
    localparam int     HOLD_CYCLES = 300;
    localparam int     DRAIN_LIMIT = 50000;
    localparam int     TAIL_CYCLES = 40;

    // How a table row is checked: by the predictor, as "no results", or as a
    // segment whose ten results all sit on one typed point.
    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_NONE,
        ROW_FLAT
    } t_row_kind;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic                     start;
        t_row_kind                kind;
        logic signed [DATA_W-1:0] ex;
        logic signed [DATA_W-1:0] ey;
    } t_dir_row;

    localparam int DIR_ROWS_N = 20;
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        // first point after reset is only stored
        '{32'sh0001_0000, 32'sh0002_0000, 1'b0, ROW_NONE, 32'sh0, 32'sh0},
        // segment from a point to itself: ten copies of it
        '{32'sh0001_0000, 32'sh0002_0000, 1'b0, ROW_FLAT, 32'sh0001_0000, 32'sh0002_0000},
        '{32'sh0003_8000, 32'shFFFE_C000, 1'b0, ROW_PRED, 32'sh0, 32'sh0},
        // equal x: plain y step with constant x
        '{32'sh0003_8000, 32'sh0004_0000, 1'b0, ROW_PRED, 32'sh0, 32'sh0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, ROW_NONE, 32'sh0, 32'sh0},
        // full swing down, then back up
        '{32'sh8000_0000, 32'sh8000_0000, 1'b0, ROW_PRED, 32'sh0, 32'sh0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, ROW_PRED, 32'sh0, 32'sh0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, ROW_FLAT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, ROW_NONE, 32'sh0, 32'sh0},
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, ROW_FLAT, 32'sh8000_0000, 32'sh7FFF_FFFF},
        // equal x at the negative extreme, y sweeps the whole range
        '{32'sh8000_0000, 32'sh8000_0000, 1'b0, ROW_PRED, 32'sh0, 32'sh0},
        '{32'sh0000_0000, 32'sh0000_0000, 1'b1, ROW_NONE, 32'sh0, 32'sh0},
        // one-LSB negative step: floor must round toward minus infinity
        '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b0, ROW_PRED, 32'sh0, 32'sh0},
        '{32'sh0000_0009, 32'shFFFF_FFF7, 1'b0, ROW_PRED, 32'sh0, 32'sh0},
        '{32'sh0000_0001, 32'sh0000_0001, 1'b0, ROW_PRED, 32'sh0, 32'sh0},
        // start right after a segment, and two starts in a row
        '{32'sh0000_0005, 32'sh0000_0005, 1'b1, ROW_NONE, 32'sh0, 32'sh0},
        '{32'sh0000_0005, 32'sh0000_0005, 1'b1, ROW_NONE, 32'sh0, 32'sh0},
        // deltas that divide evenly, then large swings
        '{32'sh0000_000F, 32'shFFFF_FFFB, 1'b0, ROW_PRED, 32'sh0, 32'sh0},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, ROW_PRED, 32'sh0, 32'sh0},
        '{32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, ROW_PRED, 32'sh0, 32'sh0}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    // Predictor state: last stored point and whether one is held.
    logic signed [DATA_W-1:0] pred_prev_x;
    logic signed [DATA_W-1:0] pred_prev_y;
    logic                     pred_have_prev;

    t_out_item segment_steps [FACTOR];
    t_out_item pending_steps [$];
    t_out_item want;

    int  mismatch_count = 0;
    int  burst_left     = 0;
    bit  no_gaps        = 1'b0;
    bit  long_hold_req  = 1'b0;

    linear_interp_upsampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // floor(num / FACTOR) for any sign of num
    function automatic longint floor_div_steps(input longint num);
        longint q;
        q = num / STEPS;
        if ((num % STEPS) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Work out the results of one accepted point into segment_steps, advance
    // the stored point, and return how many results the point causes.
    function automatic int predict_segment(input t_in_item pt);
        longint x0;
        longint y0;
        longint dx;
        longint dy;
        int     j;
        if (pt.start_req || !pred_have_prev) begin
            pred_prev_x    = pt.x_in;
            pred_prev_y    = pt.y_in;
            pred_have_prev = 1'b1;
            return 0;
        end
        x0 = longint'(pred_prev_x);
        y0 = longint'(pred_prev_y);
        dx = longint'($signed(pt.x_in)) - x0;
        dy = longint'($signed(pt.y_in)) - y0;
        for (j = 0; j < FACTOR; j++) begin
            segment_steps[j].x_out = DATA_W'(x0 + floor_div_steps(longint'(j) * dx));
            segment_steps[j].y_out = DATA_W'(y0 + floor_div_steps(longint'(j) * dy));
            segment_steps[j].phase = PHASE_W'(j);
            segment_steps[j].last  = (PHASE_W'(j) == PHASE_LAST);
        end
        pred_prev_x = pt.x_in;
        pred_prev_y = pt.y_in;
        return FACTOR;
    endfunction

    // Offer one point, hold it until the transfer, queue what it should cause,
    // then, unless no_gaps is set, idle for a random gap at the end of a burst.
    task automatic push_point(input t_in_item pt, input t_row_kind kind,
                              input logic signed [DATA_W-1:0] ex,
                              input logic signed [DATA_W-1:0] ey);
        int        n;
        int        gap;
        int        j;
        t_out_item step;
        i_in       <= pt;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        n = predict_segment(pt);
        if (kind == ROW_FLAT) begin
            for (j = 0; j < FACTOR; j++) begin
                step.x_out = ex;
                step.y_out = ey;
                step.phase = PHASE_W'(j);
                step.last  = (j == FACTOR - 1);
                pending_steps.push_back(step);
            end
        end else if (kind == ROW_PRED) begin
            for (j = 0; j < n; j++)
                pending_steps.push_back(segment_steps[j]);
        end
        if (!no_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap        = $urandom_range(1, 15);
                burst_left = $urandom_range(0, 10);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Pick a coordinate: mostly a small step from the last point, sometimes
    // a full random word or an extreme.
    function automatic logic signed [DATA_W-1:0] pick_coord(
        input logic signed [DATA_W-1:0] near);
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return 32'shFFFF_FFFF;
                endcase
            end
            default: return near + DATA_W'($urandom_range(0, 131072)) - 32'sd65536;
        endcase
    endfunction

    // Sender: reset, directed table, random stream, drain, verdict.
    initial begin
        int       r;
        int       k;
        int       wait_cycles;
        t_in_item pt;
        t_dir_row row;
        pred_prev_x    = '0;
        pred_prev_y    = '0;
        pred_have_prev = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS_N; r++) begin
            row          = DIR_ROWS[r];
            pt.x_in      = row.x;
            pt.y_in      = row.y;
            pt.start_req = row.start;
            push_point(pt, row.kind, row.ex, row.ey);
        end

        for (k = 0; k < RAND_POINTS; k++) begin
            // back-to-back points while the receiver holds off: fill the block
            if (k == 20) begin
                long_hold_req = 1'b1;
                no_gaps       = 1'b1;
            end
            if (k == 40)
                no_gaps = 1'b0;
            // drop valid and let every pending result drain
            if (k == 60) begin
                i_in_valid <= 1'b0;
                do
                    @(posedge i_clk);
                while (pending_steps.size() != 0);
            end
            pt.x_in      = pick_coord(pred_prev_x);
            pt.y_in      = pick_coord(pred_prev_y);
            pt.start_req = ($urandom_range(0, 11) == 0);
            push_point(pt, ROW_PRED, '0, '0);
        end

        i_in_valid  <= 1'b0;
        wait_cycles = 0;
        while (pending_steps.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (pending_steps.size() != 0) begin
            $error("%0d expected results never arrived", pending_steps.size());
            mismatch_count++;
        end
        // watch for stray results past the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS linear_interp_upsampler");
        else
            $display("FAIL linear_interp_upsampler");
        $finish;
    end

    // Receiver: a stall pattern that switches at random among four modes,
    // plus one long hold on request.
    initial begin
        int   mode;
        int   mode_left;
        int   cyc;
        logic rdy;
        mode        = 0;
        mode_left   = 0;
        cyc         = 0;
        i_out_ready <= 1'b0;
        do
            @(posedge i_clk);
        while (!i_rst_n);
        forever begin
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            cyc++;
            case (mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = (cyc % 4 != 3);
                default: rdy = ($urandom_range(0, 5) == 0);
            endcase
            i_out_ready <= rdy;
            @(posedge i_clk);
        end
    end

    // Compare every result transfer with the oldest pending expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_steps.size() == 0) begin
                $error("unexpected result x_out=%h y_out=%h phase=%0d",
                       o_out.x_out, o_out.y_out, o_out.phase);
                mismatch_count++;
            end else begin
                want = pending_steps.pop_front();
                if (o_out.x_out !== want.x_out) begin
                    $error("x_out expected %h got %h", want.x_out, o_out.x_out);
                    mismatch_count++;
                end
                if (o_out.y_out !== want.y_out) begin
                    $error("y_out expected %h got %h", want.y_out, o_out.y_out);
                    mismatch_count++;
                end
                if (o_out.phase !== want.phase) begin
                    $error("phase expected %0d got %0d", want.phase, o_out.phase);
                    mismatch_count++;
                end
                if (o_out.last !== want.last) begin
                    $error("last expected %b got %b", want.last, o_out.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL linear_interp_upsampler");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/liu_pkg.sv
design/liu_front.sv
design/liu_queue.sv
design/liu_back.sv
design/linear_interp_upsampler.sv
tb/tb_top.sv
